// File: sv/sssp_pkg.sv
// sssp_pkg: types, constants and sequencer states for the shortest path block
// no dependencies
package sssp_pkg;

  localparam int MAX_NODES_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 8;
  localparam int COST_BITS_DEF   = 14;

  localparam int NCOUNT_W = 7;
  localparam int MAXW_W   = 8;
  localparam int IDX_W    = 6;
  localparam int FWEIGHT_W = 8;
  localparam int PCOST_W  = 14;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_WEIGHT = 1'd1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [IDX_W-1:0]     row_index;
    logic [IDX_W-1:0]     col_index;
    logic [FWEIGHT_W-1:0] edge_weight;
    logic [IDX_W-1:0]     root_node;
    logic [IDX_W-1:0]     dest_node;
    logic                 average_mode;
  } in_item_t;

  typedef struct packed {
    logic [PCOST_W-1:0] path_cost;
    logic               dest_reached;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SEL_RD,
    S_SEL,
    S_PICK,
    S_REL_RD,
    S_REL,
    S_SUM_RD,
    S_SUM,
    S_DIV,
    S_DEST_RD,
    S_DEST,
    S_OUT
  } state_t;

endpackage

// File: sv/sssp_div.sv
// sssp_div: restoring divider, one quotient bit per cycle
// depends on sssp_pkg
module sssp_div
  import sssp_pkg::*;
#(
  parameter int NUM_W = 24,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot = q;
endmodule

// File: sv/single_source_shortest_path_top.sv
// single_source_shortest_path_top: adjacency matrix store and dijkstra sequencer
// depends on sssp_pkg and sssp_div
//
// A write beat stores one matrix entry. A solve beat runs Dijkstra from the
// root. For each settled node the sequencer makes one pass over n nodes to
// pick the cheapest open node and one pass to relax its row. Each pass gives
// every node a registered read and then a compare, with the add when
// relaxing. A last select pass finds nothing left and ends the search.
// Averaging adds a sum pass and a 21-step divide. Per-node flags are cleared
// together in the clear state at the start of a solve. The input is stalled
// from a solve beat until its result beat is taken.
module single_source_shortest_path_top
  import sssp_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int COST_BITS   = COST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int NW    = $clog2(MAX_NODES);
  localparam int NCW   = $clog2(MAX_NODES + 1);
  localparam int SUM_W = COST_BITS + NW + 1;
  localparam logic [COST_BITS-1:0] COST_MAX = '1;

  logic [NCOUNT_W-1:0] node_count;
  logic [MAXW_W-1:0]   max_weight;

  logic [WEIGHT_BITS-1:0] edge_mem [MAX_NODES*MAX_NODES];
  logic [COST_BITS-1:0]   cost_mem [MAX_NODES];
  logic [MAX_NODES-1:0]   settled, reached;

  state_t state, state_next;
  logic [NW:0]  i;
  logic [NW-1:0] best, root, dest;
  logic          have_best, avg;
  logic [COST_BITS-1:0] bcost, rd_cost;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [NCW-1:0] n;
  logic [SUM_W-1:0] sum;
  logic [COST_BITS-1:0] unreached;
  logic [MAXW_W:0] mw1;
  logic div_start, div_done;
  logic [SUM_W-1:0] quot;
  logic [NW-1:0] ii;
  logic [COST_BITS:0] cand;
  logic [COST_BITS-1:0] cand_sat;
  logic last;
  logic take_in;
  logic dest_ok;

  assign ii = i[NW-1:0];
  assign last = (i == (NW+1)'(n) - 1'b1);
  assign take_in = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    if (node_count == '0) n = NCW'(1);
    else if (32'(node_count) > MAX_NODES) n = NCW'(MAX_NODES);
    else n = NCW'(node_count);
  end

  assign mw1 = {1'b0, max_weight} + 1'b1;
  always_comb begin
    if (32'(mw1) > 32'(COST_MAX)) unreached = COST_MAX;
    else unreached = COST_BITS'(mw1);
  end

  assign cand = {1'b0, bcost} + (COST_BITS+1)'(rd_w);
  assign cand_sat = cand[COST_BITS] ? COST_MAX : cand[COST_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NCOUNT_W'(4);
      max_weight <= MAXW_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NODE_COUNT: node_count <= cfg_wdata[NCOUNT_W-1:0];
        REG_MAX_WEIGHT: max_weight <= cfg_wdata[MAXW_W-1:0];
        default: ;
      endcase
    end
  end

  // matrix port: write on write beat, read addressed by best row and current column
  always_ff @(posedge clk) begin
    if (take_in && in_data.command == CMD_WRITE &&
        32'(in_data.row_index) < MAX_NODES && 32'(in_data.col_index) < MAX_NODES)
      edge_mem[{in_data.row_index[NW-1:0], in_data.col_index[NW-1:0]}] <=
        in_data.edge_weight[WEIGHT_BITS-1:0];
    rd_w <= edge_mem[{best, ii}];
  end

  always_ff @(posedge clk) begin
    if (state == S_REL && ii != best && !settled[ii] &&
        32'(rd_w) != 32'(mw1) && (!reached[ii] || cand_sat < rd_cost))
      cost_mem[ii] <= cand_sat;
    else if (state == S_CLEAR && 32'(root) < 32'(n))
      cost_mem[root] <= '0;
    rd_cost <= cost_mem[(state == S_DEST_RD) ? dest : ii];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (take_in && in_data.command == CMD_SOLVE) state_next = S_CLEAR;
      S_CLEAR:   state_next = S_SEL_RD;
      S_SEL_RD:  state_next = S_SEL;
      S_SEL:     state_next = last ? S_PICK : S_SEL_RD;
      S_PICK:    state_next = have_best ? S_REL_RD : (avg ? S_SUM_RD : S_DEST_RD);
      S_REL_RD:  state_next = S_REL;
      S_REL:     state_next = last ? S_SEL_RD : S_REL_RD;
      S_SUM_RD:  state_next = S_SUM;
      S_SUM:     state_next = last ? S_DIV : S_SUM_RD;
      S_DIV:     if (div_done) state_next = S_OUT;
      S_DEST_RD: state_next = S_DEST;
      S_DEST:    state_next = S_OUT;
      S_OUT:     if (!out_stall) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  assign div_start = (state == S_SUM) && last;
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settled <= '0;
      reached <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (take_in) begin
          root <= in_data.root_node[NW-1:0];
          dest <= in_data.dest_node[NW-1:0];
          avg  <= in_data.average_mode;
        end
        S_CLEAR: begin
          settled <= '0;
          // a root beyond the node count reaches nothing
          reached <= (32'(root) < 32'(n)) ? (MAX_NODES'(1) << root) : '0;
          i <= '0;
          have_best <= 1'b0;
          sum <= '0;
        end
        S_SEL: begin
          if (reached[ii] && !settled[ii] && (!have_best || rd_cost < bcost)) begin
            have_best <= 1'b1;
            best <= ii;
            bcost <= rd_cost;
          end
          i <= last ? '0 : i + 1'b1;
        end
        S_PICK: begin
          i <= '0;
          if (have_best) settled[best] <= 1'b1;
        end
        S_REL: begin
          if (ii != best && !settled[ii] && 32'(rd_w) != 32'(mw1) &&
              (!reached[ii] || cand_sat < rd_cost))
            reached[ii] <= 1'b1;
          i <= last ? '0 : i + 1'b1;
          if (last) have_best <= 1'b0;
        end
        S_SUM: begin
          sum <= sum + SUM_W'(reached[ii] ? rd_cost : unreached);
          i <= last ? '0 : i + 1'b1;
        end
        S_DIV: if (div_done) begin
          out_data.path_cost    <= PCOST_W'(quot);
          out_data.dest_reached <= dest_ok && reached[dest];
        end
        S_DEST: begin
          out_data.dest_reached <= dest_ok && reached[dest];
          out_data.path_cost <= PCOST_W'((dest_ok && reached[dest]) ? rd_cost : unreached);
        end
        default: ;
      endcase
    end
  end

  // destination range, held from the solve beat
  always_ff @(posedge clk) begin
    if (state == S_IDLE && take_in)
      dest_ok <= 32'(in_data.dest_node) < MAX_NODES;
    else if (state == S_CLEAR)
      dest_ok <= dest_ok && (32'(dest) < 32'(n));
  end

  sssp_div #(.NUM_W(SUM_W), .DEN_W(NCW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(sum + SUM_W'(reached[ii] ? rd_cost : unreached)),
    .den(n), .done(div_done), .quot(quot)
  );
endmodule

// File: sv/sssp_checker.sv
// sssp_port_checks: port-level checks for the shortest path block
// depends on sssp_pkg and single_source_shortest_path_top
module sssp_port_checks
  import sssp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall
);
  // a solve beat blocks input next cycle
  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.command == CMD_SOLVE |=> in_stall)
    else $error("input not stalled after solve beat");
  // a write beat gives no result
  a_write_nores: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.command == CMD_WRITE |=> !out_valid)
    else $error("result after write beat");
  // result only while input is held off
  a_out_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("result while taking input");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");
endmodule

bind single_source_shortest_path_top sssp_port_checks u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall)
);

// File: test/sssp_checker.sv
// sssp_checker: watches the channels of the shortest path block, predicts each
// result beat and compares it; depends on sssp_pkg
`timescale 1ns / 100ps

module sssp_checker
  import sssp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int NODES    = MAX_NODES_DEF;
  localparam int COST_TOP = (1 << PCOST_W) - 1;

  logic [FWEIGHT_W-1:0] weight_mem [NODES*NODES];
  logic [NCOUNT_W-1:0]  node_cnt;
  logic [MAXW_W-1:0]    max_w;
  out_item_t            results_due [$];

  function automatic out_item_t shortest_path(input in_item_t beat);
    int        n, gap_cost, best, bcost, w, c, sum;
    int        cost [NODES];
    bit        done [NODES];
    bit        seen [NODES];
    out_item_t res;
    n = (node_cnt == 0) ? 1 : ((node_cnt > NODES) ? NODES : int'(node_cnt));
    gap_cost = int'(max_w) + 1;
    if (gap_cost > COST_TOP) gap_cost = COST_TOP;
    for (int i = 0; i < NODES; i++) begin
      cost[i] = 0;
      done[i] = 0;
      seen[i] = 0;
    end
    if (beat.root_node < n) seen[beat.root_node] = 1;
    for (int k = 0; k < n; k++) begin
      best = n;
      bcost = 0;
      // lowest index wins a tie
      for (int i = 0; i < n; i++)
        if (seen[i] && !done[i] && (best == n || cost[i] < bcost)) begin
          best = i;
          bcost = cost[i];
        end
      if (best == n) break;
      done[best] = 1;
      for (int i = 0; i < n; i++) begin
        if (i == best || done[i]) continue;
        w = weight_mem[best*NODES + i];
        if (w == int'(max_w) + 1) continue;
        c = bcost + w;
        if (c > COST_TOP) c = COST_TOP;
        if (!seen[i] || c < cost[i]) begin
          seen[i] = 1;
          cost[i] = c;
        end
      end
    end
    res.dest_reached = (beat.dest_node < n) && seen[beat.dest_node];
    if (beat.average_mode) begin
      sum = 0;
      for (int i = 0; i < n; i++) sum += seen[i] ? cost[i] : gap_cost;
      res.path_cost = PCOST_W'(sum / n);
    end else begin
      res.path_cost = PCOST_W'(res.dest_reached ? cost[beat.dest_node] : gap_cost);
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      node_cnt <= 7'd4;
      max_w <= 8'd10;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_NODE_COUNT) node_cnt <= cfg_wdata[NCOUNT_W-1:0];
        else if (cfg_addr == REG_MAX_WEIGHT) max_w <= cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        if (in_data.command == CMD_WRITE)
          weight_mem[{in_data.row_index, in_data.col_index}] = in_data.edge_weight;
        else
          results_due = {results_due, shortest_path(in_data)};
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat cost=%0d reached=%0d",
                     out_data.path_cost, out_data.dest_reached);
        end else begin
          want = results_due.pop_front();
          if (want.path_cost !== out_data.path_cost ||
              want.dest_reached !== out_data.dest_reached) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: cost exp %0d got %0d, reached exp %0d got %0d",
                       want.path_cost, out_data.path_cost,
                       want.dest_reached, out_data.dest_reached);
          end
        end
      end
      pending = results_due.size();
    end
  end

endmodule

// File: test/tb_top.sv
// tb_top: stimulus and verdict for single_source_shortest_path_top
// depends on sssp_pkg, the block and sssp_checker
`timescale 1ns / 100ps

module tb_top;
  import sssp_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;

  bit  calm;
  int  hold_reqs;
  int  hold_seen;
  int  cur_n;
  int  cur_mw;
  // matrix entries already written, so no solve reads an unwritten one
  bit  written [MAX_NODES_DEF*MAX_NODES_DEF];

  single_source_shortest_path_top i_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_addr, .cfg_wdata
  );

  sssp_checker i_checker (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_addr, .cfg_wdata,
    .fail_count, .pending
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #40_000_000;
    $display("single_source_shortest_path_top test failed");
    $finish;
  end

  // receiver: random stall, long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen++;
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 33);
    end
  end

  function automatic in_item_t edge_beat(input int r, input int c, input int w);
    in_item_t b;
    b = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    b.command = CMD_WRITE;
    b.row_index = IDX_W'(r);
    b.col_index = IDX_W'(c);
    b.edge_weight = FWEIGHT_W'(w);
    return b;
  endfunction

  function automatic in_item_t solve_beat(input int root, input int dest, input bit avg);
    in_item_t b;
    b = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    b.command = CMD_SOLVE;
    b.root_node = IDX_W'(root);
    b.dest_node = IDX_W'(dest);
    b.average_mode = avg;
    return b;
  endfunction

  function automatic int pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return cur_mw + 1;
    if (r < 85) return $urandom_range(0, cur_mw);
    return $urandom_range(0, 255);
  endfunction

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send(input in_item_t b);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_edge(input int r, input int c, input int w);
    written[r*MAX_NODES_DEF + c] = 1'b1;
    send(edge_beat(r, c, w));
  endtask

  // write every entry of the active square that is still unwritten
  task automatic fill_gaps();
    for (int r = 0; r < cur_n; r++)
      for (int c = 0; c < cur_n; c++)
        if (!written[r*MAX_NODES_DEF + c]) send_edge(r, c, pick_weight());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_regs(input int n, input int mw);
    cfg_we <= 1'b1;
    cfg_addr <= REG_NODE_COUNT;
    cfg_wdata <= CFG_DATA_W'(n);
    @(negedge clk);
    cfg_addr <= REG_MAX_WEIGHT;
    cfg_wdata <= CFG_DATA_W'(mw);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_mw = mw;
    cur_n = (n == 0) ? 1 : ((n > MAX_NODES_DEF) ? MAX_NODES_DEF : n);
  endtask

  task automatic random_phase(input int n, input int mw, input int count);
    int solve_pct;
    set_regs(n, mw);
    fill_gaps();
    solve_pct = (cur_n > 32) ? 20 : 45;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < solve_pct)
        send(solve_beat(($urandom_range(0, 9) < 8) ? $urandom_range(0, cur_n - 1)
                                                   : $urandom_range(0, 63),
                        ($urandom_range(0, 9) < 8) ? $urandom_range(0, cur_n - 1)
                                                   : $urandom_range(0, 63),
                        $urandom_range(0, 1)));
      else
        send_edge($urandom_range(0, cur_n - 1), $urandom_range(0, cur_n - 1),
                  pick_weight());
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    hold_reqs = 0;
    cur_n = 4;
    cur_mw = 10;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: four nodes, extreme weights, diagonal, out of range nodes
    set_regs(4, 10);
    send_edge(0, 1, 0);
    send_edge(1, 2, 255);
    send_edge(0, 2, 11);
    send_edge(2, 3, 12);
    send_edge(0, 0, 0);
    send_edge(1, 3, 3);
    send_edge(0, 3, 3);
    send_edge(3, 0, 11);
    send_edge(63, 63, 255);
    fill_gaps();
    send(solve_beat(0, 3, 1'b0));
    send(solve_beat(0, 0, 1'b1));
    send(solve_beat(0, 2, 1'b0));
    send(solve_beat(63, 0, 1'b0));
    send(solve_beat(63, 1, 1'b1));
    send(solve_beat(1, 63, 1'b0));
    send(solve_beat(2, 2, 1'b0));
    send(solve_beat(3, 1, 1'b1));
    send(solve_beat(1, 0, 1'b1));
    drain();

    // full-size graph: the root row has no edges, so only that row is read
    set_regs(64, 254);
    for (int c = 0; c < MAX_NODES_DEF; c++) send_edge(7, c, 255);
    send(solve_beat(7, 7, 1'b0));
    send(solve_beat(7, 20, 1'b1));
    drain();
    set_regs(127, 254);
    send(solve_beat(7, 40, 1'b1));
    drain();

    // back-to-back beats with the receiver held off
    calm = 1'b1;
    hold_reqs++;
    random_phase(3, 7, 14);
    calm = 1'b0;

    random_phase(0, 0, 8);
    random_phase(2, 255, 10);
    random_phase(5, 20, 9);

    drain();
    if (fail_count == 0 && pending == 0)
      $display("single_source_shortest_path_top test passed");
    else
      $display("single_source_shortest_path_top test failed");
    $finish;
  end

endmodule
